### rtl/flg_pkg.sv
// Shared types, codes and constants of the swept flanger.
package flg_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_STEP    = 3'd0,
    REG_BASE_DELAY    = 3'd1,
    REG_SWEEP_DEPTH   = 3'd2,
    REG_FEEDBACK_GAIN = 3'd3,
    REG_WET_MIX       = 3'd4
  } cfg_reg_t;

  localparam logic [19:0] RST_PHASE_STEP    = 20'd26844;
  localparam logic [9:0]  RST_BASE_DELAY    = 10'd48;
  localparam logic [17:0] RST_SWEEP_DEPTH   = 18'd43008;
  localparam logic [15:0] RST_FEEDBACK_GAIN = 16'd19661;
  localparam logic [16:0] RST_WET_MIX       = 17'd32768;

  // Delay in Q.8 samples before the wrap, and the number of wrap steps.
  // The delay stays below 2^19 and the line holds at least 64 samples,
  // so the quotient has at most five bits.
  localparam int D_W       = 19;
  localparam int MOD_STEPS = 5;
  localparam int STEP_W    = 3;

  // Signed width of the shared multiplier's second operand
  localparam int MB_W = 18;

  // Quarter-wave sine polynomial coefficients
  localparam logic [16:0] SIN_C7 = 17'd307;
  localparam logic [16:0] UNITY  = 17'd65536;

  function automatic logic [16:0] poly_coef(input logic [STEP_W-1:0] k);
    logic [16:0] c;
    case (k)
      3'd0:    c = 17'd5223;
      3'd1:    c = 17'd42334;
      3'd2:    c = 17'd102944;
      default: c = 17'd0;
    endcase
    return c;
  endfunction

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SQ_M,
    ST_SQ_A,
    ST_POLY_M,
    ST_POLY_A,
    ST_SIN_M,
    ST_LFO_A,
    ST_SWP_M,
    ST_DLY_A,
    ST_MOD,
    ST_RPT,
    ST_RD0,
    ST_INT0,
    ST_INT1,
    ST_INT_A,
    ST_FB_M,
    ST_FB_A,
    ST_WRITE,
    ST_WET_M,
    ST_OUT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLR,
    OP_ACCEPT,
    OP_SQ_M,
    OP_SQ_A,
    OP_POLY_M,
    OP_POLY_A,
    OP_SIN_M,
    OP_LFO_A,
    OP_SWP_M,
    OP_DLY_A,
    OP_MOD,
    OP_RPT,
    OP_RD0,
    OP_INT0,
    OP_INT1,
    OP_INT_A,
    OP_FB_M,
    OP_FB_A,
    OP_WRITE,
    OP_WET_M,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [STEP_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
  } status_t;

endpackage

### rtl/flg_ram.sv
// Generic single-write, single-read RAM with registered read data.
module flg_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/flg_ctrl.sv
// Sequencer of the flanger: clearing pass, per-item step sequence, handshakes.
module flg_ctrl import flg_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  status_t st,
  output cmd_t    cmd
);

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and step counter
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_CLEAR: if (st.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid) state_nxt = ST_SQ_M;
      ST_SQ_M:  state_nxt = ST_SQ_A;
      ST_SQ_A: begin
        state_nxt = ST_POLY_M;
        cnt_nxt   = '0;
      end
      ST_POLY_M: state_nxt = ST_POLY_A;
      ST_POLY_A: begin
        if (cnt_r == STEP_W'(2)) begin
          state_nxt = ST_SIN_M;
        end else begin
          state_nxt = ST_POLY_M;
          cnt_nxt   = cnt_r + 1'b1;
        end
      end
      ST_SIN_M: state_nxt = ST_LFO_A;
      ST_LFO_A: state_nxt = ST_SWP_M;
      ST_SWP_M: state_nxt = ST_DLY_A;
      ST_DLY_A: begin
        state_nxt = ST_MOD;
        cnt_nxt   = STEP_W'(MOD_STEPS - 1);
      end
      ST_MOD: begin
        if (cnt_r == '0) begin
          state_nxt = ST_RPT;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_RPT:   state_nxt = ST_RD0;
      ST_RD0:   state_nxt = ST_INT0;
      ST_INT0:  state_nxt = ST_INT1;
      ST_INT1:  state_nxt = ST_INT_A;
      ST_INT_A: state_nxt = ST_FB_M;
      ST_FB_M:  state_nxt = ST_FB_A;
      ST_FB_A:  state_nxt = ST_WRITE;
      ST_WRITE: state_nxt = ST_WET_M;
      ST_WET_M: state_nxt = ST_OUT;
      ST_OUT:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Commands and handshake outputs
  always_comb begin
    cmd.op        = OP_NONE;
    cmd.step      = cnt_r;
    in_stall      = (state_r != ST_IDLE);
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_CLEAR:  cmd.op = OP_CLR;
      ST_IDLE:   if (in_valid) cmd.op = OP_ACCEPT;
      ST_SQ_M:   cmd.op = OP_SQ_M;
      ST_SQ_A:   cmd.op = OP_SQ_A;
      ST_POLY_M: cmd.op = OP_POLY_M;
      ST_POLY_A: cmd.op = OP_POLY_A;
      ST_SIN_M:  cmd.op = OP_SIN_M;
      ST_LFO_A:  cmd.op = OP_LFO_A;
      ST_SWP_M:  cmd.op = OP_SWP_M;
      ST_DLY_A:  cmd.op = OP_DLY_A;
      ST_MOD:    cmd.op = OP_MOD;
      ST_RPT:    cmd.op = OP_RPT;
      ST_RD0:    cmd.op = OP_RD0;
      ST_INT0:   cmd.op = OP_INT0;
      ST_INT1:   cmd.op = OP_INT1;
      ST_INT_A:  cmd.op = OP_INT_A;
      ST_FB_M:   cmd.op = OP_FB_M;
      ST_FB_A:   cmd.op = OP_FB_A;
      ST_WRITE:  cmd.op = OP_WRITE;
      ST_WET_M:  cmd.op = OP_WET_M;
      ST_OUT: begin
        // hold the result until the output register is free
        if (out_free) begin
          cmd.op        = OP_OUT;
          out_valid_nxt = 1'b1;
        end
      end
      default:   cmd.op = OP_NONE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

### rtl/flg_dp.sv
// Datapath of the flanger: LFO, delay arithmetic, shared multiplier, delay line.
module flg_dp import flg_pkg::*; #(
  parameter int DELAY_DEPTH     = 2048,
  parameter int SAMPLE_BITS     = 24,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cmd_t                          cmd,
  output status_t                       st,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out
);

  localparam int AW  = $clog2(DELAY_DEPTH);
  localparam int MA  = ((SAMPLE_BITS > 18) ? SAMPLE_BITS : 18) + 1;
  localparam int PW  = MA + MB_W;
  localparam int RPW = AW + 9;
  localparam int MW  = RPW + MOD_STEPS;

  localparam logic [AW-1:0]      LAST_IDX = AW'(DELAY_DEPTH - 1);
  localparam logic [RPW:0]       SPAN_R   = (RPW + 1)'(DELAY_DEPTH) << 8;
  localparam logic [MW-1:0]      SPAN_M   = MW'(DELAY_DEPTH) << 8;
  localparam logic signed [PW:0] SMAX     = (PW + 1)'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [PW:0] SMIN     = -SMAX - (PW + 1)'(1);

  function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [PW:0] v);
    logic signed [SAMPLE_BITS-1:0] r;
    if (v > SMAX) begin
      r = SMAX[SAMPLE_BITS-1:0];
    end else if (v < SMIN) begin
      r = SMIN[SAMPLE_BITS-1:0];
    end else begin
      r = v[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

  // Configuration registers
  logic [19:0] phase_step_r;
  logic [9:0]  base_delay_r;
  logic [17:0] sweep_depth_r;
  logic [15:0] feedback_gain_r;
  logic [16:0] wet_mix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r    <= RST_PHASE_STEP;
      base_delay_r    <= RST_BASE_DELAY;
      sweep_depth_r   <= RST_SWEEP_DEPTH;
      feedback_gain_r <= RST_FEEDBACK_GAIN;
      wet_mix_r       <= RST_WET_MIX;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_PHASE_STEP:    phase_step_r    <= cfg_data[19:0];
        REG_BASE_DELAY:    base_delay_r    <= cfg_data[9:0];
        REG_SWEEP_DEPTH:   sweep_depth_r   <= cfg_data[17:0];
        REG_FEEDBACK_GAIN: feedback_gain_r <= cfg_data[15:0];
        REG_WET_MIX:       wet_mix_r       <= cfg_data[16:0];
        default:           ;
      endcase
    end
  end

  // Control state
  logic [31:0]   phase_r, phase_nxt;
  logic [AW-1:0] widx_r, widx_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;

  // Per-item working registers
  logic signed [SAMPLE_BITS-1:0] x_in_r, x_in_nxt;
  logic [1:0]                    quad_r, quad_nxt;
  logic [16:0]                   x_r, x_nxt;
  logic [16:0]                   x2_r, x2_nxt;
  logic [16:0]                   p_r, p_nxt;
  logic [15:0]                   lfo_r, lfo_nxt;
  logic [D_W-1:0]                d_r, d_nxt;
  logic [AW-1:0]                 r0_r, r0_nxt;
  logic [AW-1:0]                 r1_r, r1_nxt;
  logic [7:0]                    frac_r, frac_nxt;
  logic signed [PW-1:0]          prod_r, prod_nxt;
  logic signed [PW-1:0]          acc_r, acc_nxt;
  logic signed [SAMPLE_BITS-1:0] delayed_r, delayed_nxt;
  logic signed [SAMPLE_BITS-1:0] w_r, w_nxt;
  logic signed [SAMPLE_BITS-1:0] out_r, out_nxt;

  // Combinational helpers
  logic signed [MA-1:0]   ma;
  logic signed [MB_W-1:0] mb;
  logic                   mul_en;
  logic [16:0]            x_raw;
  logic [16:0]            mx;
  logic [16:0]            dry;
  logic [17:0]            s18;
  logic signed [19:0]     lfo_v;
  logic [18:0]            lfo_h;
  logic [MW-1:0]          mod_cmp;
  logic [MW-1:0]          d_ext;
  logic [RPW:0]           rp_a;
  logic [RPW:0]           rp_b;
  logic signed [PW:0]     sum_ap;
  logic signed [PW:0]     fb_sum;
  logic signed [PW:0]     mix_sh;

  // Delay line
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [AW-1:0]          ram_raddr;
  logic [SAMPLE_BITS-1:0] ram_wdata;
  logic [SAMPLE_BITS-1:0] ram_rdata;

  flg_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DELAY_DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_we    = (cmd.op == OP_CLR) || (cmd.op == OP_WRITE);
  assign ram_waddr = (cmd.op == OP_CLR) ? clr_addr_r : widx_r;
  assign ram_wdata = (cmd.op == OP_CLR) ? '0 : w_r;
  assign ram_raddr = (cmd.op == OP_INT0) ? r1_r : r0_r;

  assign st.clr_last = (clr_addr_r == LAST_IDX);

  assign mx  = (wet_mix_r > UNITY) ? UNITY : wet_mix_r;
  assign dry = UNITY - mx;

  // Shared multiplier operands
  always_comb begin
    ma     = '0;
    mb     = '0;
    mul_en = 1'b1;
    case (cmd.op)
      OP_SQ_M: begin
        ma = MA'(x_r);
        mb = MB_W'(x_r);
      end
      OP_POLY_M: begin
        ma = MA'(x2_r);
        mb = MB_W'(p_r);
      end
      OP_SIN_M: begin
        ma = MA'(x_r);
        mb = MB_W'(p_r);
      end
      OP_SWP_M: begin
        ma = MA'(sweep_depth_r);
        mb = MB_W'(lfo_r);
      end
      OP_INT0: begin
        ma = MA'($signed(ram_rdata));
        mb = MB_W'(9'd256 - 9'(frac_r));
      end
      OP_INT1: begin
        ma = MA'($signed(ram_rdata));
        mb = MB_W'(frac_r);
      end
      OP_FB_M: begin
        ma = MA'(delayed_r);
        mb = MB_W'(feedback_gain_r);
      end
      OP_WRITE: begin
        ma = MA'(x_in_r);
        mb = MB_W'(dry);
      end
      OP_WET_M: begin
        ma = MA'(delayed_r);
        mb = MB_W'(mx);
      end
      default: mul_en = 1'b0;
    endcase
  end

  assign prod_nxt = ma * mb;

  // Step arithmetic
  always_comb begin
    x_raw   = 17'(phase_r[29 -: (SINE_TABLE_BITS - 2)]) << (18 - SINE_TABLE_BITS);
    s18     = prod_r[33:16];
    lfo_v   = quad_r[1] ? (20'sd65536 - $signed({2'b00, s18}))
                        : (20'sd65536 + $signed({2'b00, s18}));
    lfo_h   = lfo_v[19:1];
    d_ext   = MW'(d_r);
    mod_cmp = SPAN_M << cmd.step;
    rp_a    = (RPW + 1)'({widx_r, 8'h00}) + SPAN_R - (RPW + 1)'(d_r);
    rp_b    = (rp_a >= SPAN_R) ? (rp_a - SPAN_R) : rp_a;
    sum_ap  = (PW + 1)'(acc_r) + (PW + 1)'(prod_r);
    fb_sum  = (((PW + 1)'(prod_r) + (PW + 1)'(32768)) >>> 16) + (PW + 1)'(x_in_r);
    mix_sh  = (sum_ap + (PW + 1)'(32768)) >>> 16;

    phase_nxt    = phase_r;
    widx_nxt     = widx_r;
    clr_addr_nxt = clr_addr_r;
    x_in_nxt     = x_in_r;
    quad_nxt     = quad_r;
    x_nxt        = x_r;
    x2_nxt       = x2_r;
    p_nxt        = p_r;
    lfo_nxt      = lfo_r;
    d_nxt        = d_r;
    r0_nxt       = r0_r;
    r1_nxt       = r1_r;
    frac_nxt     = frac_r;
    acc_nxt      = acc_r;
    delayed_nxt  = delayed_r;
    w_nxt        = w_r;
    out_nxt      = out_r;

    case (cmd.op)
      OP_CLR: clr_addr_nxt = clr_addr_r + 1'b1;
      OP_ACCEPT: begin
        // sample the LFO angle, then advance the phase
        x_in_nxt  = in_sample_in;
        quad_nxt  = phase_r[31:30];
        x_nxt     = phase_r[30] ? (UNITY - x_raw) : x_raw;
        phase_nxt = phase_r + 32'(phase_step_r);
      end
      OP_SQ_A: begin
        x2_nxt = prod_r[32:16];
        p_nxt  = SIN_C7;
      end
      OP_POLY_A: p_nxt = poly_coef(cmd.step) - prod_r[32:16];
      OP_LFO_A: begin
        if (lfo_v < 0) begin
          lfo_nxt = '0;
        end else if (lfo_h > 19'd65535) begin
          lfo_nxt = 16'hFFFF;
        end else begin
          lfo_nxt = lfo_h[15:0];
        end
      end
      OP_DLY_A: d_nxt = D_W'({base_delay_r, 8'h00}) + D_W'(prod_r[33:16]);
      OP_MOD: begin
        // subtract the line span shifted by the step, restoring style
        if (d_ext >= mod_cmp) d_nxt = D_W'(d_ext - mod_cmp);
      end
      OP_RPT: begin
        r0_nxt   = rp_b[AW+7:8];
        r1_nxt   = (rp_b[AW+7:8] == LAST_IDX) ? '0 : rp_b[AW+7:8] + 1'b1;
        frac_nxt = rp_b[7:0];
      end
      OP_INT1:  acc_nxt = prod_r;
      OP_INT_A: delayed_nxt = SAMPLE_BITS'((sum_ap + (PW + 1)'(128)) >>> 8);
      OP_FB_A:  w_nxt = sat(fb_sum);
      OP_WRITE: widx_nxt = (widx_r == LAST_IDX) ? '0 : widx_r + 1'b1;
      OP_WET_M: acc_nxt = prod_r;
      OP_OUT:   out_nxt = sat(mix_sh);
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= '0;
      widx_r     <= '0;
      clr_addr_r <= '0;
    end else begin
      phase_r    <= phase_nxt;
      widx_r     <= widx_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_in_r    <= x_in_nxt;
    quad_r    <= quad_nxt;
    x_r       <= x_nxt;
    x2_r      <= x2_nxt;
    p_r       <= p_nxt;
    lfo_r     <= lfo_nxt;
    d_r       <= d_nxt;
    r0_r      <= r0_nxt;
    r1_r      <= r1_nxt;
    frac_r    <= frac_nxt;
    acc_r     <= acc_nxt;
    delayed_r <= delayed_nxt;
    w_r       <= w_nxt;
    out_r     <= out_nxt;
    if (mul_en) begin
      prod_r <= prod_nxt;
    end
  end

  assign out_sample_out = out_r;

endmodule

### rtl/lfo_swept_flanger.sv
// Top level of the LFO-swept flanger with interpolated delay and feedback.
// One sample in gives one sample out. After reset the block runs a clearing
// pass over all DELAY_DEPTH entries of the delay line, during which in_stall
// is high; configuration writes are taken at any time. Each item is worked
// through to the end before the next is accepted: the sine polynomial, sweep
// product, interpolation, feedback and mix all go through one shared
// multiplier with a registered product, and the delay wrap takes five subtract
// steps. The result appears on out_sample_out and is held in an output
// register while the next item is being worked on.
module lfo_swept_flanger import flg_pkg::*; #(
  parameter int DELAY_DEPTH     = 2048,
  parameter int SAMPLE_BITS     = 24,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  cmd_t    cmd;
  status_t st;
  logic    cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  flg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  flg_dp #(
    .DELAY_DEPTH     (DELAY_DEPTH),
    .SAMPLE_BITS     (SAMPLE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_sample_in   (in_sample_in),
    .out_sample_out (out_sample_out)
  );

endmodule
